/* hdl/assert_macros.svh */
// Assertion helper macros for the grid automaton RTL.
// Included by files that check their own control logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// cond must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* hdl/lat_pkg.sv */
// Shared types, constants and helpers for the toroidal life automaton.
// No dependencies; used by every module of the block.
package lat_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam int DIM_W = 7;   // width / height register
  localparam int IDX_W = 6;   // row index field
  localparam int ROW_W = 64;  // row word on the ports
  localparam int CNT_W = 4;   // neighbor count 0..8

  localparam logic [DIM_W-1:0] RESET_DIM   = DIM_W'(30);
  localparam logic [CNT_W-1:0] BIRTH_COUNT = CNT_W'(3);
  localparam logic [CNT_W-1:0] KEEP_COUNT  = CNT_W'(2);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_EVOLVE = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  // control broadcast to every row cell
  typedef struct packed {
    logic             shift;     // rotate the active ring by one row
    logic             load;      // write load_row into the addressed cell
    logic [IDX_W-1:0] load_idx;
    logic [DIM_W-1:0] hgt;       // effective height, ring length
  } cell_ctl_t;

  // 0 reads as 1, values above the maximum saturate
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v,
                                               logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

endpackage

/* hdl/life_automaton_torus.sv */
// Toroidal B3/S23 life grid, up to MAX_HEIGHT rows of MAX_WIDTH cells.
// Load beat: taken while idle. Evolve beat: accepted while idle, then a sweep at
// one row per cycle while the result port is not stalled; a result stall holds
// the sweep. After a height change the first evolve adds a scan of the ring.
// New rows leave through the output register. Reset: all cells dead, width and height 30.
module life_automaton_torus import lat_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write port
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_data_i,
  // input beats
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             operation_i,
  input  logic [IDX_W-1:0] load_row_index_i,
  input  logic [ROW_W-1:0] load_row_cells_i,
  // result beats
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [IDX_W-1:0] out_row_index_o,
  output logic [ROW_W-1:0] out_row_cells_o,
  output logic             last_row_o
);

`include "assert_macros.svh"

  localparam logic [DIM_W-1:0] MaxWd = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MaxHt = DIM_W'(MAX_HEIGHT);

  // IDLE: take loads and evolves. SCAN: rotate the ring once to pick up the
  // last active row after a height change. SWEEP: one new row per cycle unless stalled.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_SWEEP = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;          // row under work
  logic [DIM_W-1:0]     wid_q, wid_d;          // effective width
  logic [DIM_W-1:0]     hgt_q, hgt_d;          // effective height
  logic                 last_ok_q, last_ok_d;  // shadow_q holds row h-1
  logic [MAX_WIDTH-1:0] shadow_q, shadow_d;    // copy of row h-1
  logic [MAX_WIDTH-1:0] first_q, first_d;      // old row 0 during a sweep
  logic [MAX_WIDTH-1:0] prev_q, prev_d;        // old row above the current one

  // output register
  logic                 out_vld_q, out_vld_d;
  logic [IDX_W-1:0]     out_idx_q, out_idx_d;
  logic [MAX_WIDTH-1:0] out_cells_q, out_cells_d;
  logic                 out_last_q, out_last_d;

  logic [MAX_WIDTH-1:0] rows [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] load_row, wb_row, up_row, dn_row, nxt_row;
  logic [DIM_W-1:0]     hgt_m1;
  logic                 cnt_last, h_one;
  cell_ctl_t            ctl;

  assign load_row = load_row_cells_i[MAX_WIDTH-1:0];
  assign hgt_m1   = hgt_q - DIM_W'(1);
  assign cnt_last = DIM_W'(cnt_q) == hgt_m1;
  assign h_one    = hgt_q == DIM_W'(1);

  // ---- ring of row cells: cell 0 is the head, rows move down by one ----
  for (genvar i = 0; i < MAX_HEIGHT; i++) begin : g_cell
    logic [MAX_WIDTH-1:0] nbr;
    if (i < MAX_HEIGHT - 1) begin : g_mid
      assign nbr = rows[i+1];
    end else begin : g_end
      assign nbr = '0;   // top cell only ever takes the tail row
    end
    lat_row_cell #(
      .MAX_WIDTH (MAX_WIDTH),
      .IDX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .nbr_i      (nbr),
      .wb_i       (wb_row),
      .load_row_i (load_row),
      .row_o      (rows[i])
    );
  end

  // ---- neighbor rows for the head row ----
  // head holds old row y; cell 1 holds old row y+1 until the wrap, where
  // the saved old row 0 stands in. A one-row grid sees itself above and below.
  assign up_row = h_one ? rows[0] : ((cnt_q == '0) ? shadow_q : prev_q);
  assign dn_row = h_one ? rows[0] : (cnt_last ? first_q : rows[1]);

  lat_rule #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_rule (
    .up_i  (up_row),
    .mid_i (rows[0]),
    .dn_i  (dn_row),
    .wid_i (wid_q),
    .nxt_o (nxt_row)
  );

  // scan rotates rows unchanged, sweep writes the new row back at the tail
  assign wb_row = (state_q == ST_SCAN) ? rows[0] : nxt_row;

  // ---- control ----
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    wid_d        = wid_q;
    hgt_d        = hgt_q;
    last_ok_d    = last_ok_q;
    shadow_d     = shadow_q;
    first_d      = first_q;
    prev_d       = prev_q;
    out_vld_d    = out_vld_q;
    out_idx_d    = out_idx_q;
    out_cells_d  = out_cells_q;
    out_last_d   = out_last_q;
    ctl.shift    = 1'b0;
    ctl.load     = 1'b0;
    ctl.load_idx = load_row_index_i;
    ctl.hgt      = hgt_q;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_WIDTH: begin
          wid_d = eff_dim(cfg_data_i, MaxWd);
        end
        REG_GRID_HEIGHT: begin
          hgt_d     = eff_dim(cfg_data_i, MaxHt);
          last_ok_d = 1'b0;   // shadow row no longer the last one
        end
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (operation_i == OP_EVOLVE) begin
            cnt_d   = '0;
            state_d = last_ok_q ? ST_SWEEP : ST_SCAN;
          end else begin
            ctl.load = 1'b1;
            if (DIM_W'(load_row_index_i) == hgt_m1) begin
              shadow_d = load_row;
            end
          end
        end
      end
      ST_SCAN: begin
        ctl.shift = 1'b1;
        cnt_d     = cnt_q + IDX_W'(1);
        if (cnt_last) begin
          shadow_d  = rows[0];
          last_ok_d = 1'b1;
          cnt_d     = '0;
          state_d   = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        // advance only when the output register is free or drains now
        if (!out_vld_q || !out_stall_i) begin
          ctl.shift   = 1'b1;
          out_vld_d   = 1'b1;
          out_idx_d   = cnt_q;
          out_cells_d = nxt_row;
          out_last_d  = cnt_last;
          prev_d      = rows[0];
          cnt_d       = cnt_q + IDX_W'(1);
          if (cnt_q == '0) begin
            first_d = rows[0];
          end
          if (cnt_last) begin
            shadow_d = nxt_row;   // new row h-1 is next evolve's upper wrap
            cnt_d    = '0;
            state_d  = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      wid_q     <= eff_dim(RESET_DIM, MaxWd);
      hgt_q     <= eff_dim(RESET_DIM, MaxHt);
      last_ok_q <= 1'b1;   // all rows dead, shadow zero
      shadow_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      wid_q     <= wid_d;
      hgt_q     <= hgt_d;
      last_ok_q <= last_ok_d;
      shadow_q  <= shadow_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q     <= first_d;
    prev_q      <= prev_d;
    out_idx_q   <= out_idx_d;
    out_cells_q <= out_cells_d;
    out_last_q  <= out_last_d;
  end

  assign in_stall_o      = state_q != ST_IDLE;
  assign out_valid_o     = out_vld_q;
  assign out_row_index_o = out_idx_q;
  assign out_row_cells_o = ROW_W'(out_cells_q);
  assign last_row_o      = out_last_q;

  // ---- checks ----
  `ASSERT_AT(a_out_src, clk_i, rst_ni, $rose(out_vld_q) |-> $past(state_q == ST_SWEEP), "stray beat")
  `ASSERT_AT(a_last_top, clk_i, rst_ni, out_vld_q && out_last_q |-> DIM_W'(out_idx_q) == hgt_m1, "bad last")
  `ASSERT_AT(a_cnt_ring, clk_i, rst_ni, state_q != ST_IDLE |-> DIM_W'(cnt_q) < hgt_q, "cnt past height")

endmodule

/* hdl/lat_row_cell.sv */
// One row cell of the grid ring: holds one row word, takes a load, its neighbor's
// row or, as the ring tail, the incoming tail row. Depends on lat_pkg.
module lat_row_cell import lat_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int IDX       = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctl_t            ctl_i,
  input  logic [MAX_WIDTH-1:0] nbr_i,      // row of the next cell up the chain
  input  logic [MAX_WIDTH-1:0] wb_i,       // row entering at the ring tail
  input  logic [MAX_WIDTH-1:0] load_row_i,
  output logic [MAX_WIDTH-1:0] row_o
);

  localparam logic [DIM_W-1:0] IdxD = DIM_W'(IDX);
  localparam logic [IDX_W-1:0] IdxI = IDX_W'(IDX);

  logic [MAX_WIDTH-1:0] row_d, row_q;

  always_comb begin
    row_d = row_q;
    if (ctl_i.load && ctl_i.load_idx == IdxI) begin
      row_d = load_row_i;
    end else if (ctl_i.shift && IdxD < ctl_i.hgt) begin
      // tail cell of the active ring closes the loop
      row_d = (IdxD == ctl_i.hgt - DIM_W'(1)) ? wb_i : nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

/* hdl/lat_rule.sv */
// B3/S23 next-row unit: one full row from the rows above, at and below,
// with horizontal wrap at the active width. Depends on lat_pkg.
module lat_rule import lat_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic [MAX_WIDTH-1:0] up_i,
  input  logic [MAX_WIDTH-1:0] mid_i,
  input  logic [MAX_WIDTH-1:0] dn_i,
  input  logic [DIM_W-1:0]     wid_i,
  output logic [MAX_WIDTH-1:0] nxt_o
);

  localparam int WB = $clog2(MAX_WIDTH);

  logic [MAX_WIDTH-1:0] msk;
  logic [MAX_WIDTH-1:0] up_m, mid_m, dn_m;
  logic [MAX_WIDTH-1:0] ul, ur, ml, mr, dl, dr;
  logic [WB-1:0]        sh;

  assign sh = WB'(wid_i - DIM_W'(1));

  for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_msk
    assign msk[x] = DIM_W'(x) < wid_i;
  end

  assign up_m  = up_i & msk;
  assign mid_m = mid_i & msk;
  assign dn_m  = dn_i & msk;

  // left: bit x sees column x-1; right: bit x sees column x+1 (mod width)
  assign ul = ((up_m << 1) | (up_m >> sh)) & msk;
  assign ur = ((up_m >> 1) | (MAX_WIDTH'(up_m[0]) << sh)) & msk;
  assign ml = ((mid_m << 1) | (mid_m >> sh)) & msk;
  assign mr = ((mid_m >> 1) | (MAX_WIDTH'(mid_m[0]) << sh)) & msk;
  assign dl = ((dn_m << 1) | (dn_m >> sh)) & msk;
  assign dr = ((dn_m >> 1) | (MAX_WIDTH'(dn_m[0]) << sh)) & msk;

  for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_col
    logic [CNT_W-1:0] cnt;
    assign cnt = CNT_W'(ul[x]) + CNT_W'(up_m[x]) + CNT_W'(ur[x])
               + CNT_W'(ml[x]) + CNT_W'(mr[x])
               + CNT_W'(dl[x]) + CNT_W'(dn_m[x]) + CNT_W'(dr[x]);
    assign nxt_o[x] = msk[x] & ((cnt == BIRTH_COUNT) || (mid_m[x] && cnt == KEEP_COUNT));
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Testbench for life_automaton_torus: row loads, B3/S23 generations on a torus.
// Depends on lat_pkg and the RTL only; predicts every emitted row and checks it.
module tb;
  import lat_pkg::*;

  localparam int MAX_COLS      = 64;
  localparam int MAX_ROWS      = 64;
  localparam int SETTLE_CYCLES = 150;      // covers a height-change scan plus a full sweep
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int REPORT_LIMIT  = 10;

  // receiver stall styles
  localparam int STALL_NONE    = 0;
  localparam int STALL_RANDOM  = 1;
  localparam int STALL_PATTERN = 2;
  localparam int STALL_HEAVY   = 3;

  typedef struct {
    logic [IDX_W-1:0] row_idx;
    logic [ROW_W-1:0] cells;
    logic             last_flag;
  } gen_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [0:0]       cfg_idx_i;
  logic [DIM_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             operation_i;
  logic [IDX_W-1:0] load_row_index_i;
  logic [ROW_W-1:0] load_row_cells_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [IDX_W-1:0] out_row_index_o;
  logic [ROW_W-1:0] out_row_cells_o;
  logic             last_row_o;

  // shadow copy of the grid and its size registers
  logic [ROW_W-1:0] shadow_rows [MAX_ROWS];
  logic [DIM_W-1:0] shadow_width;
  logic [DIM_W-1:0] shadow_height;
  gen_row_t         gen_rows_due [$];

  int  err_count     = 0;
  int  cycle_count   = 0;
  int  stall_mode    = STALL_NONE;
  logic [7:0] stall_pattern = 8'b0110_1001;
  int  hold_request  = 0;
  int  hold_left     = 0;
  bit  gaps_on       = 1'b0;
  int  burst_left    = 0;

  life_automaton_torus dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .load_row_index_i (load_row_index_i),
    .load_row_cells_i (load_row_cells_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_row_index_o  (out_row_index_o),
    .out_row_cells_o  (out_row_cells_o),
    .last_row_o       (last_row_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost row ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stall generator. A long hold-off request overrides the current style
  // and is counted down here, so the block has to buffer and push back.
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM:  out_stall_i <= ($urandom_range(0, 2) == 0);
        STALL_PATTERN: out_stall_i <= stall_pattern[cycle_count % 8];
        STALL_HEAVY:   out_stall_i <= ((cycle_count % 4) != 0);
        default:       out_stall_i <= 1'b0;
      endcase
    end
  end

  // Result checker: every accepted result beat against the oldest predicted row.
  always @(posedge clk_i) begin
    gen_row_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (gen_rows_due.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_LIMIT)
          $display("unexpected result beat: idx %0d cells %h last %b",
                   out_row_index_o, out_row_cells_o, last_row_o);
      end else begin
        due = gen_rows_due.pop_front();
        if (out_row_index_o !== due.row_idx || out_row_cells_o !== due.cells ||
            last_row_o !== due.last_flag) begin
          err_count++;
          if (err_count <= REPORT_LIMIT)
            $display("row mismatch: expected idx %0d cells %h last %b, got idx %0d cells %h last %b",
                     due.row_idx, due.cells, due.last_flag,
                     out_row_index_o, out_row_cells_o, last_row_o);
        end
      end
    end
  end

  // 0 acts as 1, anything above the cap saturates
  function automatic int clamp_dim(logic [DIM_W-1:0] v, int cap);
    int r;
    r = int'(v);
    if (r == 0) r = 1;
    if (r > cap) r = cap;
    return r;
  endfunction

  // Row contents with a mix of densities so patterns actually evolve.
  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0:       return a & b;
      1:       return a | b;
      2:       return '0;
      3:       return '1;
      4:       return ROW_W'(1) << $urandom_range(0, ROW_W - 1);
      5:       return a & b & {$urandom, $urandom};
      default: return a;
    endcase
  endfunction

  // Next generation of the shadow grid on the old grid, wrapping at the active
  // size; bits above the width are ignored and come out as zero.
  task automatic predict_generation();
    logic [ROW_W-1:0] old_rows [MAX_ROWS];
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] fresh;
    int w, h, cnt;
    w = clamp_dim(shadow_width, MAX_COLS);
    h = clamp_dim(shadow_height, MAX_ROWS);
    mask = (w >= ROW_W) ? '1 : ((ROW_W'(1) << w) - 1);
    for (int y = 0; y < h; y++) old_rows[y] = shadow_rows[y] & mask;
    for (int y = 0; y < h; y++) begin
      fresh = '0;
      for (int x = 0; x < w; x++) begin
        cnt = 0;
        // tiny grids may see the same cell more than once; each position counts
        for (int dy = -1; dy <= 1; dy++)
          for (int dx = -1; dx <= 1; dx++)
            if (dy != 0 || dx != 0)
              cnt += int'(old_rows[(y + dy + h) % h][(x + dx + w) % w]);
        if (cnt == 3 || (old_rows[y][x] && cnt == 2)) fresh[x] = 1'b1;
      end
      shadow_rows[y] = fresh;
      gen_rows_due.push_back('{row_idx: IDX_W'(y), cells: fresh, last_flag: (y == h - 1)});
    end
  endtask

  // One input beat; sender gaps come in bursts when enabled.
  task automatic send_item(input op_e op, input logic [IDX_W-1:0] idx,
                           input logic [ROW_W-1:0] cells);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(1, 10);
      end
      burst_left--;
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    load_row_index_i <= idx;
    load_row_cells_i <= cells;
    do @(posedge clk_i); while (in_stall_o);
    if (op == OP_LOAD) shadow_rows[idx] = cells;
    else predict_generation();
  endtask

  // Drop valid, let all predicted rows drain, then let any trailing work finish.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (gen_rows_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the width register, then the height register; call only when idle.
  task automatic set_grid_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_GRID_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i  <= REG_GRID_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    shadow_width  = w;
    shadow_height = h;
  endtask

  // Freshly reset grid at the reset size: thirty dead rows.
  task automatic test_reset_state();
    send_item(OP_EVOLVE, '0, '0);
  endtask

  // Glider across the corner wrap, blinker with junk above the width,
  // and a row above the height that must be left alone.
  task automatic test_wrapped_patterns();
    send_item(OP_LOAD, 6'd28, 64'h0000_0000_0000_0001);
    send_item(OP_LOAD, 6'd29, 64'h0000_0000_0000_0002);
    send_item(OP_LOAD, 6'd0,  64'h0000_0000_2000_0003);
    send_item(OP_LOAD, 6'd10, 64'hFFFF_FFFF_C000_1C00);
    send_item(OP_LOAD, 6'd40, '1);
    send_item(OP_EVOLVE, 6'd63, '1);
    send_item(OP_EVOLVE, '0, '0);
    send_item(OP_EVOLVE, 6'd17, 64'h5A5A_5A5A_5A5A_5A5A);
  endtask

  // Size zero reads as one; single cell is its own eight neighbors.
  task automatic test_tiny_grids();
    wait_quiet();
    set_grid_size(7'd0, 7'd0);
    send_item(OP_LOAD, 6'd0, '1);
    send_item(OP_EVOLVE, '0, '0);
    wait_quiet();
    set_grid_size(7'd2, 7'd2);
    send_item(OP_LOAD, 6'd0, 64'h0000_0000_0000_0001);
    send_item(OP_LOAD, 6'd1, 64'hF000_0000_0000_0003);
    send_item(OP_EVOLVE, '0, '0);
    send_item(OP_EVOLVE, '0, '0);
  endtask

  // Oversized writes saturate to the full 64 by 64 grid; also height one.
  task automatic test_full_grid();
    wait_quiet();
    set_grid_size(7'd127, 7'd127);
    send_item(OP_LOAD, 6'd0,  '1);
    send_item(OP_LOAD, 6'd63, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_LOAD, 6'd31, 64'h8000_0001_0180_0000);
    send_item(OP_EVOLVE, '0, '0);
    send_item(OP_EVOLVE, '0, '0);
    wait_quiet();
    set_grid_size(7'd64, 7'd1);
    send_item(OP_LOAD, 6'd0, 64'h0F0F_3C3C_E007_1111);
    send_item(OP_EVOLVE, '0, '0);
  endtask

  // Receiver holds off for a long stretch while evolves keep coming.
  task automatic test_backpressure();
    wait_quiet();
    set_grid_size(7'd12, 7'd12);
    stall_mode = STALL_NONE;
    gaps_on = 1'b0;
    for (int r = 0; r < 12; r++) send_item(OP_LOAD, IDX_W'(r), rand_row());
    hold_request = 600;
    for (int n = 0; n < 10; n++) send_item(OP_EVOLVE, '0, '0);
  endtask

  // Phases at many sizes, extremes first; mostly loads inside the active
  // height, some stray loads anywhere, and evolves with junk in ignored fields.
  task automatic test_random_configs();
    logic [DIM_W-1:0] w_set, h_set;
    logic [IDX_W-1:0] idx;
    int h;
    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       begin w_set = 7'd3;   h_set = 7'd3;   end
        1:       begin w_set = 7'd64;  h_set = 7'd64;  end
        2:       begin w_set = 7'd1;   h_set = 7'd1;   end
        3:       begin w_set = 7'd2;   h_set = 7'd2;   end
        4:       begin w_set = 7'd0;   h_set = 7'd127; end
        5:       begin w_set = 7'd127; h_set = 7'd0;   end
        6:       begin w_set = 7'd1;   h_set = 7'd64;  end
        7:       begin w_set = 7'd65;  h_set = 7'd2;   end
        default: begin
          w_set = DIM_W'($urandom_range(1, 70));
          h_set = DIM_W'($urandom_range(1, 20));
        end
      endcase
      wait_quiet();
      set_grid_size(w_set, h_set);
      stall_mode = p % 4;
      stall_pattern = 8'($urandom) & 8'h7F;
      gaps_on = (p % 3 != 0);
      burst_left = 0;
      h = clamp_dim(h_set, MAX_ROWS);
      for (int i = 0; i < 25; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(OP_EVOLVE, IDX_W'($urandom), rand_row());
        end else begin
          if ($urandom_range(0, 4) == 0) idx = IDX_W'($urandom_range(0, MAX_ROWS - 1));
          else idx = IDX_W'($urandom_range(0, h - 1));
          send_item(OP_LOAD, idx, rand_row());
        end
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = REG_GRID_WIDTH;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    operation_i      = OP_LOAD;
    load_row_index_i = '0;
    load_row_cells_i = '0;
    out_stall_i      = 1'b0;
    for (int r = 0; r < MAX_ROWS; r++) shadow_rows[r] = '0;
    shadow_width  = RESET_DIM;
    shadow_height = RESET_DIM;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_wrapped_patterns();
    test_tiny_grids();
    test_full_grid();
    test_backpressure();
    test_random_configs();

    stall_mode = STALL_NONE;
    wait_quiet();
    if (err_count == 0 && gen_rows_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
